@@ rtl/arc_pkg.sv @@
// arc_pkg: shared codes for the address resolution cache.
// No dependencies.
package arc_pkg;
  localparam logic [2:0] FUNC_LOOKUP_IP  = 3'd0;
  localparam logic [2:0] FUNC_LOOKUP_MAC = 3'd1;
  localparam logic [2:0] FUNC_INSERT     = 3'd2;
  localparam logic [2:0] FUNC_REMOVE     = 3'd3;
  localparam logic [2:0] FUNC_TICK       = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_DISABLED = 2'd2;

  localparam logic [0:0] REG_ENABLE  = 1'd0;
  localparam logic [0:0] REG_TIMEOUT = 1'd1;

  localparam int unsigned IP_W       = 32;
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam logic [15:0] TIMEOUT_RST = 16'd60;
endpackage

@@ rtl/arc_ram.sv @@
// arc_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module arc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/address_resolution_cache.sv @@
// address_resolution_cache: top level, scan controller over entry RAM.
// Depends on arc_pkg and arc_ram.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  command | start && !busy       | func_i ip_addr_i mac_addr_i slot_index_i
//  result  | done (one cycle)     | status_o entry_index_o found_ip_o found_mac_o
//  config  | cfg_we_i             | cfg_index_i cfg_data_i
//
// Lookup, insert and tick scan every entry through one RAM read port, one entry
// per cycle: the registered read comes first, then the compare of each entry,
// then a finish state, then done. Insert adds a write state before finish.
// Remove, disabled and unused codes go straight from accept to the finish state.
// The scan sweep over the RAM read port sets the rate. Valid bits sit in
// flip-flops cleared at reset; RAM contents need no reset. done is a one-cycle
// strobe, the receiver cannot stall it.
module address_resolution_cache #(
  parameter int unsigned ENTRIES   = 32,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  func_i,
  input  logic [31:0] ip_addr_i,
  input  logic [47:0] mac_addr_i,
  input  logic [4:0]  slot_index_i,
  output logic        done,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_index_o,
  output logic [31:0] found_ip_o,
  output logic [47:0] found_mac_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WRITE, S_FINISH} state_e;

  state_e              state_q;
  logic                enabled_q;
  logic [15:0]         timeout_q;
  logic [ENTRIES-1:0]  valid_q;
  logic [TIME_BITS-1:0] time_q;
  logic [2:0]          func_q;
  logic [31:0]         ip_q;
  logic [47:0]         mac_q;
  logic [CW-1:0]       rcnt_q;   // read address counter
  logic [CW-1:0]       ccnt_q;   // compare counter (one behind)
  logic                hit_q, free_q;
  logic [AW-1:0]       hit_idx_q, free_idx_q, old_idx_q;
  logic [TIME_BITS-1:0] old_age_q;
  logic                old_any_q;
  logic [1:0]          status_q;
  logic [4:0]          idx_q;
  logic [31:0]         fip_q;
  logic [47:0]         fmac_q;
  logic                done_q;

  // RAM ports
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic                wr_ip;
  logic [31:0]         rd_ip;
  logic [47:0]         rd_mac;
  logic [TIME_BITS-1:0] rd_stamp;

  assign raddr = rcnt_q[AW-1:0];

  arc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_ip (
    .clk_i, .we_i(we && wr_ip), .waddr_i(waddr), .wdata_i(ip_q),
    .raddr_i(raddr), .rdata_o(rd_ip));
  arc_ram #(.WIDTH(48), .DEPTH(ENTRIES)) u_mac (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(mac_q),
    .raddr_i(raddr), .rdata_o(rd_mac));
  arc_ram #(.WIDTH(TIME_BITS), .DEPTH(ENTRIES)) u_stamp (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(time_q),
    .raddr_i(raddr), .rdata_o(rd_stamp));

  // Compare stage on the entry read last cycle.
  logic [AW-1:0]        cidx;
  logic                 cvalid, cmatch;
  logic [TIME_BITS-1:0] cage;
  assign cidx   = ccnt_q[AW-1:0];
  assign cvalid = valid_q[cidx];
  assign cage   = time_q - rd_stamp;
  assign cmatch = cvalid && ((func_q == arc_pkg::FUNC_LOOKUP_MAC) ? (rd_mac == mac_q)
                                                                  : (rd_ip == ip_q));

  // Insert target: matching IP, else lowest free, else oldest.
  logic [AW-1:0] ins_idx;
  always_comb begin
    priority if (hit_q) ins_idx = hit_idx_q;
    else if (free_q)    ins_idx = free_idx_q;
    else                ins_idx = old_idx_q;
  end
  assign we    = (state_q == S_WRITE);
  assign waddr = ins_idx;
  assign wr_ip = !hit_q;

  logic scanning, scan_last;
  assign scanning  = (state_q == S_SCAN) && (ccnt_q != '1) ;
  assign scan_last = (state_q == S_SCAN) && (ccnt_q == CW'(ENTRIES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      enabled_q <= 1'b0;
      timeout_q <= arc_pkg::TIMEOUT_RST;
      valid_q   <= '0;
      time_q    <= '0;
      done_q    <= 1'b0;
      rcnt_q    <= '0;
      ccnt_q    <= '1;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          arc_pkg::REG_ENABLE:  enabled_q <= cfg_data_i[0];
          arc_pkg::REG_TIMEOUT: timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            func_q    <= func_i;
            ip_q      <= ip_addr_i;
            mac_q     <= mac_addr_i;
            hit_q     <= 1'b0;
            free_q    <= 1'b0;
            old_any_q <= 1'b0;
            hit_idx_q <= '0; free_idx_q <= '0; old_idx_q <= '0; old_age_q <= '0;
            status_q  <= arc_pkg::ST_OK;
            idx_q     <= '0;
            fip_q     <= '0;
            fmac_q    <= '0;
            rcnt_q    <= '0;
            ccnt_q    <= '1;
            state_q   <= S_FINISH;
            if (!enabled_q) begin
              status_q <= arc_pkg::ST_DISABLED;
            end else begin
              priority case (func_i)
                arc_pkg::FUNC_LOOKUP_IP, arc_pkg::FUNC_LOOKUP_MAC,
                arc_pkg::FUNC_INSERT: begin
                  state_q <= S_SCAN;
                end
                arc_pkg::FUNC_TICK: begin
                  time_q  <= time_q + 1'b1;
                  state_q <= S_SCAN;
                end
                arc_pkg::FUNC_REMOVE: begin
                  idx_q <= slot_index_i;
                  if (32'(slot_index_i) < ENTRIES)
                    valid_q[AW'(slot_index_i)] <= 1'b0;
                end
                default: ;
              endcase
            end
          end
        end
        S_SCAN: begin
          if (rcnt_q != CW'(ENTRIES)) rcnt_q <= rcnt_q + 1'b1;
          ccnt_q <= ccnt_q + 1'b1;
          if (scanning) begin
            if (cmatch && !hit_q && func_q != arc_pkg::FUNC_TICK) begin
              hit_q <= 1'b1; hit_idx_q <= cidx;
              if (func_q != arc_pkg::FUNC_INSERT) begin
                idx_q  <= 5'(cidx);
                fip_q  <= rd_ip;
                fmac_q <= rd_mac;
              end
            end
            if (!cvalid && !free_q) begin
              free_q <= 1'b1; free_idx_q <= cidx;
            end
            if (!old_any_q || cage > old_age_q) begin
              old_any_q <= 1'b1; old_age_q <= cage; old_idx_q <= cidx;
            end
            if (func_q == arc_pkg::FUNC_TICK && cvalid && 64'(cage) > 64'(timeout_q))
              valid_q[cidx] <= 1'b0;
          end
          if (scan_last) begin
            state_q <= (func_q == arc_pkg::FUNC_INSERT) ? S_WRITE : S_FINISH;
            if ((func_q == arc_pkg::FUNC_LOOKUP_IP || func_q == arc_pkg::FUNC_LOOKUP_MAC)
                && !(hit_q || cmatch))
              status_q <= arc_pkg::ST_MISS;
          end
        end
        S_WRITE: begin
          valid_q[ins_idx] <= 1'b1;
          idx_q   <= 5'(ins_idx);
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done          = done_q;
  assign status_o      = status_q;
  assign entry_index_o = idx_q;
  assign found_ip_o    = fip_q;
  assign found_mac_o   = fmac_q;
endmodule

@@ rtl/arc_checker.sv @@
// arc_checker: port-level assertions for address_resolution_cache.
// Depends on arc_pkg; bound to the top level below.
module arc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status_o,
  input logic [4:0] entry_index_o
);
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> !done) else $error("done held two cycles");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !busy) else $error("busy during done");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (status_o == arc_pkg::ST_OK || status_o == arc_pkg::ST_MISS ||
              status_o == arc_pkg::ST_DISABLED)) else $error("bad status");
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && status_o != arc_pkg::ST_OK) |-> entry_index_o == 5'd0)
    else $error("index on refused item");
endmodule

bind address_resolution_cache arc_checker u_arc_checker (
  .clk_i, .rst_ni, .start, .busy, .done, .status_o, .entry_index_o);

@@ tb/sv/tb_address_resolution_cache.sv @@
// tb_address_resolution_cache: self-checking bench for the address resolution cache.
// It drives a directed table and then random traffic, and checks each result against
// a predictor of the table kept inside the bench. Depends on arc_pkg and the RTL top.
module tb_address_resolution_cache;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_ENTRIES = 32;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned CALM_TAIL = 150;     // last items run with no gaps
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;   // a bit more than one full scan

  typedef struct packed {
    logic [1:0]                status;
    logic [arc_pkg::IDX_W-1:0] idx;
    logic [arc_pkg::IP_W-1:0]  ip;
    logic [arc_pkg::MAC_W-1:0] mac;
  } arc_result_t;

  // One row of the directed table: either a register write or a command.
  typedef struct {
    bit                        is_cfg;
    logic [0:0]                reg_idx;
    logic [15:0]               reg_val;
    logic [2:0]                func;
    logic [arc_pkg::IP_W-1:0]  ip;
    logic [arc_pkg::MAC_W-1:0] mac;
    logic [arc_pkg::IDX_W-1:0] slot;
    bit                        has_exp;  // typed-in expectation, else predictor only
    arc_result_t               exp;
  } dir_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [2:0]       func_i = arc_pkg::FUNC_TICK;
  logic [31:0]      ip_addr_i = '0;
  logic [47:0]      mac_addr_i = '0;
  logic [4:0]       slot_index_i = '0;
  logic             done;
  logic [1:0]       status_o;
  logic [4:0]       entry_index_o;
  logic [31:0]      found_ip_o;
  logic [47:0]      found_mac_o;
  logic             cfg_we_i = 1'b0;
  logic [0:0]       cfg_index_i = arc_pkg::REG_ENABLE;
  logic [15:0]      cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  address_resolution_cache u_top (
    .clk_i, .rst_ni, .start, .busy, .func_i, .ip_addr_i, .mac_addr_i, .slot_index_i,
    .done, .status_o, .entry_index_o, .found_ip_o, .found_mac_o,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the table, the tick counter and registers.
  // ---------------------------------------------------------------------------
  bit                        tbl_valid [NUM_ENTRIES];
  logic [arc_pkg::IP_W-1:0]  tbl_ip    [NUM_ENTRIES];
  logic [arc_pkg::MAC_W-1:0] tbl_mac   [NUM_ENTRIES];
  logic [31:0]               tbl_stamp [NUM_ENTRIES];
  logic [31:0]               now_ticks;
  bit                        enabled;
  logic [15:0]               timeout_ticks;

  arc_result_t      expected_q[$];
  int unsigned      mismatches = 0;
  int unsigned      results_seen = 0;
  int unsigned      cycles = 0;
  int unsigned      hits_seen = 0;
  int unsigned      evictions = 0;
  dir_row_t         dir_rows[$];

  // Lowest valid entry matching by IP (use_mac=0) or MAC; -1 on miss.
  function automatic int find_slot(bit use_mac, logic [arc_pkg::IP_W-1:0] ip,
                                   logic [arc_pkg::MAC_W-1:0] mac);
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (tbl_valid[i] && (use_mac ? tbl_mac[i] == mac : tbl_ip[i] == ip)) return i;
    end
    return -1;
  endfunction

  // Apply one command to the table copy and return the result it gives.
  function automatic arc_result_t resolve_cmd(logic [2:0] fn, logic [arc_pkg::IP_W-1:0] ip,
                                              logic [arc_pkg::MAC_W-1:0] mac,
                                              logic [arc_pkg::IDX_W-1:0] slot);
    arc_result_t r;
    int          hit;
    int          target;
    logic [31:0] best_age;
    logic [31:0] age;
    r = '0;
    if (!enabled) begin
      r.status = arc_pkg::ST_DISABLED;
    end else begin
      case (fn)
        arc_pkg::FUNC_LOOKUP_IP, arc_pkg::FUNC_LOOKUP_MAC: begin
          hit = find_slot(fn == arc_pkg::FUNC_LOOKUP_MAC, ip, mac);
          if (hit < 0) begin
            r.status = arc_pkg::ST_MISS;
          end else begin
            r.idx = hit[arc_pkg::IDX_W-1:0];
            r.ip  = tbl_ip[hit];
            r.mac = tbl_mac[hit];
            hits_seen++;
          end
        end
        arc_pkg::FUNC_INSERT: begin
          // same IP first, then lowest free slot, then oldest (lowest index on ties)
          target = find_slot(1'b0, ip, mac);
          if (target < 0) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
              if (!tbl_valid[i]) begin
                target = i;
                break;
              end
            end
            if (target < 0) begin
              evictions++;
              target = 0;
              best_age = now_ticks - tbl_stamp[0];
              for (int i = 1; i < NUM_ENTRIES; i++) begin
                age = now_ticks - tbl_stamp[i];
                if (age > best_age) begin
                  best_age = age;
                  target = i;
                end
              end
            end
            tbl_ip[target] = ip;
          end
          tbl_mac[target]   = mac;
          tbl_stamp[target] = now_ticks;
          tbl_valid[target] = 1'b1;
          r.idx = target[arc_pkg::IDX_W-1:0];
        end
        arc_pkg::FUNC_REMOVE: begin
          r.idx = slot;
          tbl_valid[slot] = 1'b0;  // a 5-bit index is always inside 32 entries
        end
        arc_pkg::FUNC_TICK: begin
          now_ticks = now_ticks + 1;
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (tbl_valid[i] && (now_ticks - tbl_stamp[i]) > {16'd0, timeout_ticks})
              tbl_valid[i] = 1'b0;
          end
        end
        default: ;  // unused codes: all-zero result, no change
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: done is a one-cycle strobe, sampled at the edge ending it.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    arc_result_t want;
    if (rst_ni && done) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", 128'({status_o, entry_index_o}), '0);
      end else begin
        want = expected_q.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 128'(status_o), 128'(want.status));
        if (entry_index_o !== want.idx)
          report_mismatch("entry_index", 128'(entry_index_o), 128'(want.idx));
        if (found_ip_o !== want.ip)
          report_mismatch("found_ip", 128'(found_ip_o), 128'(want.ip));
        if (found_mac_o !== want.mac)
          report_mismatch("found_mac", 128'(found_mac_o), 128'(want.mac));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All are entered and left right after a rising edge.
  // ---------------------------------------------------------------------------

  // Present one item and hold it until accepted (start high, busy low).
  // start is left high; the caller lowers it only if it idles next.
  task automatic issue_cmd(logic [2:0] fn, logic [arc_pkg::IP_W-1:0] ip,
                           logic [arc_pkg::MAC_W-1:0] mac,
                           logic [arc_pkg::IDX_W-1:0] slot, bit has_exp, arc_result_t exp);
    arc_result_t pred;
    start        <= 1'b1;
    func_i       <= fn;
    ip_addr_i    <= ip;
    mac_addr_i   <= mac;
    slot_index_i <= slot;
    do @(posedge clk_i); while (busy);
    pred = resolve_cmd(fn, ip, mac, slot);
    if (has_exp && pred !== exp)
      report_mismatch("table row vs predictor", 128'(pred), 128'(exp));
    expected_q.push_back(has_exp ? exp : pred);
  endtask

  task automatic idle_cycles(int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Lower start and hold off until every pending result is back.
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == arc_pkg::REG_ENABLE) enabled = val[0];
    else timeout_ticks = val;
  endtask

  function automatic void add_cmd(logic [2:0] fn, logic [arc_pkg::IP_W-1:0] ip,
                                  logic [arc_pkg::MAC_W-1:0] mac,
                                  logic [arc_pkg::IDX_W-1:0] slot, bit has_exp = 0,
                                  arc_result_t exp = '0);
    dir_row_t row;
    row = '{default: '0};
    row.func = fn; row.ip = ip; row.mac = mac; row.slot = slot;
    row.has_exp = has_exp; row.exp = exp;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_reg(logic [0:0] idx, logic [15:0] val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1; row.reg_idx = idx; row.reg_val = val;
    dir_rows.push_back(row);
  endfunction

  // Address pool so that random lookups and inserts hit existing entries.
  logic [arc_pkg::IP_W-1:0]  ip_pool  [48];
  logic [arc_pkg::MAC_W-1:0] mac_pool [48];

  function automatic logic [arc_pkg::MAC_W-1:0] rand_mac();
    return {16'($urandom_range(16'hffff, 0)), $urandom()};
  endfunction

  // One random command with weighted operation mix.
  task automatic random_cmd();
    int unsigned               pick;
    int unsigned               p;
    logic [2:0]                fn;
    logic [arc_pkg::IP_W-1:0]  ip;
    logic [arc_pkg::MAC_W-1:0] mac;
    pick = $urandom_range(99);
    p    = $urandom_range(47);
    if (pick < 35)      fn = arc_pkg::FUNC_INSERT;
    else if (pick < 55) fn = arc_pkg::FUNC_LOOKUP_IP;
    else if (pick < 70) fn = arc_pkg::FUNC_LOOKUP_MAC;
    else if (pick < 80) fn = arc_pkg::FUNC_REMOVE;
    else if (pick < 96) fn = arc_pkg::FUNC_TICK;
    else                fn = 3'($urandom_range(7, 5));
    // mostly pooled addresses, sometimes fully random ones to cover every bit
    ip  = ($urandom_range(9) == 0) ? arc_pkg::IP_W'($urandom()) : ip_pool[p];
    mac = ($urandom_range(9) == 0) ? rand_mac() : mac_pool[$urandom_range(47)];
    if (fn == arc_pkg::FUNC_INSERT && $urandom_range(3) != 0) mac = mac_pool[p];
    issue_cmd(fn, ip, mac, arc_pkg::IDX_W'($urandom()), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned sent;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0; tbl_ip[i] = '0; tbl_mac[i] = '0; tbl_stamp[i] = '0;
    end
    now_ticks = '0;
    enabled = 1'b0;
    timeout_ticks = arc_pkg::TIMEOUT_RST;
    for (int i = 0; i < 48; i++) begin
      ip_pool[i]  = 32'h0a00_0000 | arc_pkg::IP_W'($urandom_range(255));
      mac_pool[i] = rand_mac();
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Typed expectations where obvious from the spec.
    add_cmd(arc_pkg::FUNC_TICK, '0, '0, '0, 1, '{arc_pkg::ST_DISABLED, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_LOOKUP_IP, '1, '1, '1, 1, '{arc_pkg::ST_DISABLED, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_INSERT, 32'h0102_0304, 48'h0a0b_0c0d_0e0f, '0, 1,
            '{arc_pkg::ST_DISABLED, 5'd0, '0, '0});
    add_reg(arc_pkg::REG_ENABLE, 16'd1);
    add_cmd(arc_pkg::FUNC_LOOKUP_IP, '0, '0, '0, 1, '{arc_pkg::ST_MISS, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_LOOKUP_MAC, '1, '1, '0, 1, '{arc_pkg::ST_MISS, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_INSERT, '0, '0, '0, 1, '{arc_pkg::ST_OK, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_INSERT, '1, '1, '1, 1, '{arc_pkg::ST_OK, 5'd1, '0, '0});
    add_cmd(arc_pkg::FUNC_LOOKUP_IP, '1, '0, '0, 1, '{arc_pkg::ST_OK, 5'd1, '1, '1});
    add_cmd(arc_pkg::FUNC_LOOKUP_MAC, '1, '0, '0, 1, '{arc_pkg::ST_OK, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_INSERT, '1, 48'h1234_5678_9abc, '0, 0);   // same IP: update in place
    add_cmd(arc_pkg::FUNC_LOOKUP_MAC, '0, 48'h1234_5678_9abc, '0, 0);
    add_cmd(arc_pkg::FUNC_REMOVE, '0, '0, 5'd31, 1, '{arc_pkg::ST_OK, 5'd31, '0, '0});
    add_cmd(arc_pkg::FUNC_REMOVE, '0, '0, 5'd0, 1, '{arc_pkg::ST_OK, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_LOOKUP_IP, '0, '0, '0, 1, '{arc_pkg::ST_MISS, 5'd0, '0, '0});
    add_cmd(3'd5, '1, '1, '1, 1, '{arc_pkg::ST_OK, 5'd0, '0, '0});
    add_cmd(3'd6, '1, '1, '1, 1, '{arc_pkg::ST_OK, 5'd0, '0, '0});
    add_cmd(3'd7, '0, '0, '0, 1, '{arc_pkg::ST_OK, 5'd0, '0, '0});
    // aging at timeout 1: entry survives one tick, dies on the second
    add_reg(arc_pkg::REG_TIMEOUT, 16'd1);
    add_cmd(arc_pkg::FUNC_TICK, '0, '0, '0, 1, '{arc_pkg::ST_OK, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_LOOKUP_IP, '1, '0, '0, 0);
    add_cmd(arc_pkg::FUNC_TICK, '0, '0, '0, 1, '{arc_pkg::ST_OK, 5'd0, '0, '0});
    add_cmd(arc_pkg::FUNC_LOOKUP_IP, '1, '0, '0, 1, '{arc_pkg::ST_MISS, 5'd0, '0, '0});

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else issue_cmd(dir_rows[i].func, dir_rows[i].ip, dir_rows[i].mac, dir_rows[i].slot,
                     dir_rows[i].has_exp, dir_rows[i].exp);
    end

    // Fill the table past capacity with no ticks so eviction ties go to index 0,
    // then with ticks in between so ages differ.
    write_reg(arc_pkg::REG_TIMEOUT, 16'hffff);
    for (int i = 0; i < 40; i++) begin
      issue_cmd(arc_pkg::FUNC_INSERT, ip_pool[i], mac_pool[i], '0, 1'b0, '0);
      if (i >= 34) issue_cmd(arc_pkg::FUNC_TICK, '0, '0, '0, 1'b0, '0);
    end

    // Random phases over several register settings, timeout 1 and 65535 included.
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_reg(arc_pkg::REG_TIMEOUT, arc_pkg::TIMEOUT_RST);
        1: write_reg(arc_pkg::REG_TIMEOUT, 16'd1);
        2: write_reg(arc_pkg::REG_ENABLE, 16'd0);
        3: begin
          write_reg(arc_pkg::REG_ENABLE, 16'd1);
          write_reg(arc_pkg::REG_TIMEOUT, 16'd3);
        end
        4: write_reg(arc_pkg::REG_TIMEOUT, 16'hffff);
        default: write_reg(arc_pkg::REG_TIMEOUT, 16'($urandom_range(12, 2)));
      endcase
      for (int n = 0; n < (phase == 2 ? 40 : 242); n++) begin
        random_cmd();
        sent++;
        // idle bursts, none in the calm tail of the run
        if (sent < RANDOM_ITEMS - CALM_TAIL && $urandom_range(3) == 0)
          idle_cycles($urandom_range(4, 1));
        // sender pauses once mid-phase until the block has fully drained
        if (phase == 1 && n == 100) wait_drained();
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d results, %0d lookup hits, %0d evictions, final tick count %0d",
             results_seen, hits_seen, evictions, now_ticks);
    $display("register settings: disabled and enabled, timeout 1, 3, 60 and 65535");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/arc_pkg.sv
rtl/arc_ram.sv
rtl/address_resolution_cache.sv
rtl/arc_checker.sv
tb/sv/tb_address_resolution_cache.sv
